/* rtl/framed_attribute_packet_parser_top_macros.svh */
// Assertion macros for the top level of the framed attribute packet parser.
`ifndef FRAMED_ATTRIBUTE_PACKET_PARSER_TOP_MACROS_SVH
`define FRAMED_ATTRIBUTE_PACKET_PARSER_TOP_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define FAPP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define FAPP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/fapp_pkg.sv */
// Shared types and constants of the framed attribute packet parser.
package fapp_pkg;

  // Default largest packet length in bytes, start flag included.
  localparam int unsigned MaxPacketBytesDef = 255;

  // Depth of the result queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_X       = 3'd0,
    CFG_START_Y       = 3'd1,
    CFG_START_Z       = 3'd2,
    CFG_END_FLAG      = 3'd3,
    CFG_ATTR_FIRST    = 3'd4,
    CFG_ATTR_LAST     = 3'd5,
    CFG_PAYLOAD_FIRST = 3'd6
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [7:0] StartXRst       = 8'd1;
  localparam logic [7:0] StartYRst       = 8'd2;
  localparam logic [7:0] StartZRst       = 8'd3;
  localparam logic [7:0] EndFlagRst      = 8'd4;
  localparam logic [7:0] AttrFirstRst    = 8'd5;
  localparam logic [7:0] AttrLastRst     = 8'd31;
  localparam logic [7:0] PayloadFirstRst = 8'd32;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_ECHO     = 3'd0,
    KIND_RECORD   = 3'd1,
    KIND_OK       = 3'd2,
    KIND_FORMAT   = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  // One result transaction.
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  ptype;
    logic [31:0] ident;
    logic [7:0]  attr;
    logic [31:0] value;
    logic [7:0]  count;
    logic [7:0]  pbyte;
    logic        last;
  } res_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  // Queue status seen by the parser and the top level.
  typedef struct packed {
    logic                 room;
    logic [QueueCntW-1:0] count;
  } qstat_t;

endpackage

/* rtl/fapp_front.sv */
// Byte classifier and packet state machine of the framed attribute packet parser.
module fapp_front #(
  parameter int unsigned MAX_PACKET_BYTES = fapp_pkg::MaxPacketBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fapp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [7:0]                      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      byte_in_i,
  input  fapp_pkg::qstat_t                qstat_i,
  output fapp_pkg::push_t                 push_o
);
  import fapp_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PACKET_BYTES + 2);

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_IDENT = 3'd1,
    PH_ATTR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_SKIP  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    TYPE_X = 2'd0,
    TYPE_Y = 2'd1,
    TYPE_Z = 2'd2
  } ptype_e;

  // Configuration registers.
  logic [7:0] start_x_q, start_y_q, start_z_q, end_flag_q;
  logic [7:0] attr_first_q, attr_last_q, pay_first_q;

  // Packet state.
  phase_e          phase_q, phase_d;
  ptype_e          type_q, type_d;
  logic [31:0]     ident_q, ident_d;
  logic [7:0]      attr_q, attr_d;
  logic [31:0]     value_q, value_d;
  logic [7:0]      gc_q, gc_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] len_inc;

  logic       accept;
  logic       is_pay, is_attr, is_end;
  logic [7:0] gc_inc;
  push_t      push;

  // Attribute step outcome for the current byte.
  logic   ap_emit;
  kind_e  ap_kind;
  phase_e ap_phase;

  // Adds one 7-bit group at the position given by the group count.
  function automatic logic [31:0] absorb(logic [31:0] acc, logic [7:0] gc, logic [7:0] b);
    logic [31:0] grp;
    grp = {25'd0, b[6:0]};
    unique case (gc)
      8'd0:    absorb = acc | grp;
      8'd1:    absorb = acc | (grp << 7);
      8'd2:    absorb = acc | (grp << 14);
      8'd3:    absorb = acc | (grp << 21);
      8'd4:    absorb = acc | (grp << 28);
      default: absorb = acc;
    endcase
  endfunction

  // Builds a result with the packet fields of the current packet.
  function automatic res_t mk(kind_e k, logic [1:0] t, logic [31:0] id, logic [7:0] a,
                              logic [31:0] v, logic [7:0] c, logic [7:0] pb, logic l);
    res_t r;
    r.kind  = k;
    r.ptype = t;
    r.ident = id;
    r.attr  = a;
    r.value = v;
    r.count = c;
    r.pbyte = pb;
    r.last  = l;
    mk = r;
  endfunction

  assign in_stall_o = !qstat_i.room;
  assign accept     = in_valid_i && !in_stall_o;

  // Byte classes under the current configuration.
  assign is_pay  = (byte_in_i >= pay_first_q) || (byte_in_i == 8'd0);
  assign is_attr = (byte_in_i >= attr_first_q) && (byte_in_i <= attr_last_q);
  assign is_end  = (byte_in_i == end_flag_q);
  assign gc_inc  = (gc_q == 8'hFF) ? gc_q : gc_q + 8'd1;
  assign len_inc = len_q + LenW'(1);

  // Attribute phase decision: new attribute, end of packet or format error.
  always_comb begin
    ap_emit  = 1'b0;
    ap_kind  = KIND_OK;
    ap_phase = PH_DATA;
    priority if (is_attr) begin
      ap_phase = PH_DATA;
    end else if (is_end) begin
      ap_emit  = 1'b1;
      ap_kind  = KIND_OK;
      ap_phase = PH_WAIT;
    end else begin
      ap_emit  = 1'b1;
      ap_kind  = KIND_FORMAT;
      ap_phase = PH_SKIP;
    end
  end

  // Next state and the results of the accepted byte.
  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    ident_d = ident_q;
    attr_d  = attr_q;
    value_d = value_q;
    gc_d    = gc_q;
    len_d   = len_q;
    push    = '0;
    if (accept) begin
      unique case (phase_q)
        PH_WAIT: begin
          if ((byte_in_i == start_x_q) || (byte_in_i == start_y_q)
              || (byte_in_i == start_z_q)) begin
            priority if (byte_in_i == start_x_q) type_d = TYPE_X;
            else if (byte_in_i == start_y_q) type_d = TYPE_Y;
            else type_d = TYPE_Z;
            phase_d = PH_IDENT;
            ident_d = '0;
            attr_d  = '0;
            value_d = '0;
            gc_d    = '0;
            len_d   = LenW'(1);
          end
        end
        default: begin
          len_d = len_inc;
          if (len_inc > LenW'(MAX_PACKET_BYTES)) begin
            // Packet too long: abort with a single overflow result.
            push.v0 = 1'b1;
            push.r0 = mk(KIND_OVERFLOW, type_q, ident_q, '0, '0, '0, '0, 1'b1);
            phase_d = PH_WAIT;
          end else begin
            unique case (phase_q)
              PH_IDENT: begin
                if (is_pay) begin
                  ident_d = absorb(ident_q, gc_q, byte_in_i);
                  gc_d    = gc_inc;
                  push.v0 = 1'b1;
                  push.r0 = mk(KIND_ECHO, type_q, ident_d, '0, '0, '0, byte_in_i, 1'b1);
                end else begin
                  gc_d    = '0;
                  phase_d = ap_phase;
                  if (is_attr) begin
                    attr_d  = byte_in_i;
                    value_d = '0;
                  end
                  push.v0 = ap_emit;
                  push.r0 = mk(ap_kind, type_q, ident_q, '0, '0, '0, '0, 1'b1);
                end
              end
              PH_DATA: begin
                if (is_pay) begin
                  value_d = absorb(value_q, gc_q, byte_in_i);
                  gc_d    = gc_inc;
                  push.v0 = 1'b1;
                  push.r0 = mk(KIND_ECHO, type_q, ident_q, '0, '0, '0, byte_in_i, 1'b1);
                end else begin
                  // Record of the finished attribute, then the attribute step.
                  push.v0 = 1'b1;
                  push.r0 = mk(KIND_RECORD, type_q, ident_q, attr_q, value_q, gc_q, '0,
                               !ap_emit);
                  push.v1 = ap_emit;
                  push.r1 = mk(ap_kind, type_q, ident_q, '0, '0, '0, '0, 1'b1);
                  phase_d = ap_phase;
                  gc_d    = '0;
                  value_d = '0;
                  attr_d  = is_attr ? byte_in_i : 8'd0;
                end
              end
              PH_ATTR: begin
                phase_d = ap_phase;
                if (is_attr) begin
                  attr_d  = byte_in_i;
                  value_d = '0;
                  gc_d    = '0;
                end
                push.v0 = ap_emit;
                push.r0 = mk(ap_kind, type_q, ident_q, '0, '0, '0, '0, 1'b1);
              end
              default: begin
                // Skipping after a format error until the end flag.
                if (is_end) phase_d = PH_WAIT;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign push_o = push;

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= StartXRst;
      start_y_q    <= StartYRst;
      start_z_q    <= StartZRst;
      end_flag_q   <= EndFlagRst;
      attr_first_q <= AttrFirstRst;
      attr_last_q  <= AttrLastRst;
      pay_first_q  <= PayloadFirstRst;
      phase_q      <= PH_WAIT;
      type_q       <= TYPE_X;
      ident_q      <= '0;
      attr_q       <= '0;
      value_q      <= '0;
      gc_q         <= '0;
      len_q        <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      ident_q <= ident_d;
      attr_q  <= attr_d;
      value_q <= value_d;
      gc_q    <= gc_d;
      len_q   <= len_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_START_X:       start_x_q    <= cfg_wdata_i;
          CFG_START_Y:       start_y_q    <= cfg_wdata_i;
          CFG_START_Z:       start_z_q    <= cfg_wdata_i;
          CFG_END_FLAG:      end_flag_q   <= cfg_wdata_i;
          CFG_ATTR_FIRST:    attr_first_q <= cfg_wdata_i;
          CFG_ATTR_LAST:     attr_last_q  <= cfg_wdata_i;
          CFG_PAYLOAD_FIRST: pay_first_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/fapp_back.sv */
// Result queue and output register of the framed attribute packet parser.
module fapp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fapp_pkg::push_t  push_i,
  output fapp_pkg::qstat_t qstat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fapp_pkg::res_t   out_res_o
);
  import fapp_pkg::*;

  res_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 out_valid_q;
  res_t                 out_q;
  logic                 load;
  logic [QueueCntW-1:0] n_push;

  // The output register refills from the queue when empty or taken.
  assign load   = (!out_valid_q || !out_stall_i) && (count_q != '0);
  assign n_push = QueueCntW'(push_i.v0) + QueueCntW'(push_i.v1);

  always_comb begin
    count_d = count_q + n_push - QueueCntW'(load);
  end

  // Room for the largest burst one byte can cause.
  assign qstat_o.room  = count_q <= QueueCntW'(QueueDepth - 2);
  assign qstat_o.count = count_q;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem[wr_ptr_q] <= push_i.r0;
    if (push_i.v1) mem[wr_ptr_q + QueuePtrW'(1)] <= push_i.r1;
    if (load) out_q <= mem[rd_ptr_q];
  end

  // Pointers, fill count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(n_push);
      count_q  <= count_d;
      if (load) begin
        rd_ptr_q    <= rd_ptr_q + QueuePtrW'(1);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

/* rtl/framed_attribute_packet_parser_top.sv */
// Top level of the framed attribute packet parser.
// Usage:
//   The input channel (in_valid_i, in_stall_o, byte_in_i) takes one received byte per
//   transaction. The output channel (out_valid_o, out_stall_i and the result fields)
//   gives payload echoes, attribute records, packet ok, format error and overflow
//   results; last_of_run_o marks the final result caused by one input byte.
//   The configuration port (cfg_we_i, cfg_index_i, cfg_wdata_i) writes the flag and
//   range registers; write it only while the block is idle.
// Flow:
//   A result enters the four-entry result queue when its byte is accepted, then the
//   output register. The parser takes one byte per cycle, but stalls its input while
//   fewer than two queue entries are free. A byte that ends an attribute and also
//   closes the packet or breaks the format gives two results, which the output drains
//   at one per cycle when not stalled; the queue separates parser and output.
// Reset:
//   rst_ni clears the parser to wait for a start flag, empties the queue and loads
//   the default flag values. No clearing pass is needed.
// Output stall:
//   A stalled result holds; the parser keeps taking bytes until fewer than two queue entries are free.
`include "framed_attribute_packet_parser_top_macros.svh"

module framed_attribute_packet_parser_top #(
  parameter int unsigned MAX_PACKET_BYTES = fapp_pkg::MaxPacketBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fapp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   byte_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   result_kind_o,
  output logic [1:0]                   packet_type_o,
  output logic [31:0]                  packet_ident_o,
  output logic [7:0]                   attribute_code_o,
  output logic [31:0]                  decoded_value_o,
  output logic [7:0]                   data_count_o,
  output logic [7:0]                   payload_byte_o,
  output logic                         last_of_run_o
);
  import fapp_pkg::*;

  push_t  push;
  qstat_t qstat;
  res_t   res;

  // Front: byte classification and packet state.
  fapp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .qstat_i    (qstat),
    .push_o     (push)
  );

  // Back: result queue and output register.
  fapp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .qstat_o    (qstat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (res)
  );

  // Result fields.
  assign result_kind_o    = res.kind;
  assign packet_type_o    = res.ptype;
  assign packet_ident_o   = res.ident;
  assign attribute_code_o = res.attr;
  assign decoded_value_o  = res.value;
  assign data_count_o     = res.count;
  assign payload_byte_o   = res.pbyte;
  assign last_of_run_o    = res.last;

  // Checks on queue bounds and result contents.
  `FAPP_ASSERT_NEVER(a_queue_bound, qstat.count > QueueCntW'(QueueDepth), "queue overfilled")
  `FAPP_ASSERT_IMPLIES(a_plain_fields, out_valid_o && (result_kind_o != KIND_RECORD), (attribute_code_o == 8'd0) && (decoded_value_o == 32'd0) && (data_count_o == 8'd0), "record fields set on a non-record result")
  `FAPP_ASSERT_IMPLIES(a_echo_last, out_valid_o && (result_kind_o == KIND_ECHO), last_of_run_o, "payload echo not marked last")

endmodule

/* tb/fapp_tb_pkg.sv */
// Result scoreboard with a bytewise parser predictor for the framed attribute packet parser.
`timescale 1ns / 100ps
package fapp_tb_pkg;
  import fapp_pkg::*;

  // Parser phases as the predictor tracks them.
  typedef enum logic [2:0] {
    PH_WAIT,
    PH_IDENT,
    PH_ATTR,
    PH_DATA,
    PH_SKIP
  } parse_phase_e;

  class parse_scoreboard;
    // Flag and range registers as last written.
    bit [7:0]     start_x;
    bit [7:0]     start_y;
    bit [7:0]     start_z;
    bit [7:0]     end_flag;
    bit [7:0]     attr_first;
    bit [7:0]     attr_last;
    bit [7:0]     payload_first;

    // Parser state.
    parse_phase_e phase;
    bit [1:0]     cur_type;
    bit [31:0]    ident;
    bit [7:0]     cur_attr;
    bit [31:0]    acc;
    bit [7:0]     groups;
    int unsigned  pkt_len;
    int unsigned  max_len;

    // Results still owed by the block, oldest first.
    res_t         pending_results[$];
    int unsigned  errors;

    // Results caused by the byte under evaluation.
    res_t         run_buf[2];
    int unsigned  run_len;

    function new(int unsigned max_bytes);
      max_len       = max_bytes;
      start_x       = StartXRst;
      start_y       = StartYRst;
      start_z       = StartZRst;
      end_flag      = EndFlagRst;
      attr_first    = AttrFirstRst;
      attr_last     = AttrLastRst;
      payload_first = PayloadFirstRst;
      phase         = PH_WAIT;
      cur_type      = '0;
      ident         = '0;
      cur_attr      = '0;
      acc           = '0;
      groups        = '0;
      pkt_len       = 0;
      errors        = 0;
      run_len       = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [7:0] v);
      case (idx)
        CFG_START_X:       start_x = v;
        CFG_START_Y:       start_y = v;
        CFG_START_Z:       start_z = v;
        CFG_END_FLAG:      end_flag = v;
        CFG_ATTR_FIRST:    attr_first = v;
        CFG_ATTR_LAST:     attr_last = v;
        CFG_PAYLOAD_FIRST: payload_first = v;
        default: ;
      endcase
    endfunction

    function bit is_data_byte(bit [7:0] b);
      return (b >= payload_first) || (b == 8'd0);
    endfunction

    function bit is_attr(bit [7:0] b);
      return (b >= attr_first) && (b <= attr_last);
    endfunction

    // Adds one 7-bit group; groups past the 32nd bit fall off the top.
    function bit [31:0] absorb(bit [31:0] acc_in, bit [7:0] b);
      bit [31:0] sum;
      sum = acc_in;
      if (groups < 8'd5) begin
        sum = sum | ({25'd0, b[6:0]} << (7 * groups));
      end
      if (groups != 8'hFF) begin
        groups++;
      end
      return sum;
    endfunction

    function void push(kind_e k, bit [7:0] a, bit [31:0] v, bit [7:0] c, bit [7:0] pb);
      res_t r;
      if (run_len < 2) begin
        r.kind  = k;
        r.ptype = cur_type;
        r.ident = ident;
        r.attr  = a;
        r.value = v;
        r.count = c;
        r.pbyte = pb;
        r.last  = 1'b0;
        run_buf[run_len] = r;
        run_len++;
      end
    endfunction

    // A byte where an attribute code is allowed: new attribute, packet end or error.
    function void attr_step(bit [7:0] b);
      if (is_attr(b)) begin
        cur_attr = b;
        acc      = '0;
        groups   = '0;
        phase    = PH_DATA;
      end else if (b == end_flag) begin
        push(KIND_OK, 8'd0, 32'd0, 8'd0, 8'd0);
        phase = PH_WAIT;
      end else begin
        push(KIND_FORMAT, 8'd0, 32'd0, 8'd0, 8'd0);
        phase = PH_SKIP;
      end
    endfunction

    // Notes one accepted byte and queues what it causes. Returns 0 for an ignored byte.
    function bit take_byte(bit [7:0] b);
      run_len = 0;
      if (phase == PH_WAIT) begin
        if (b == start_x) begin
          cur_type = 2'd0;
        end else if (b == start_y) begin
          cur_type = 2'd1;
        end else if (b == start_z) begin
          cur_type = 2'd2;
        end else begin
          return 1'b0;
        end
        phase    = PH_IDENT;
        ident    = '0;
        cur_attr = '0;
        acc      = '0;
        groups   = '0;
        pkt_len  = 1;
        return 1'b1;
      end

      pkt_len++;
      if (pkt_len > max_len) begin
        push(KIND_OVERFLOW, 8'd0, 32'd0, 8'd0, 8'd0);
        phase = PH_WAIT;
      end else begin
        case (phase)
          PH_IDENT: begin
            if (is_data_byte(b)) begin
              ident = absorb(ident, b);
              push(KIND_ECHO, 8'd0, 32'd0, 8'd0, b);
            end else begin
              groups = '0;
              phase  = PH_ATTR;
              attr_step(b);
            end
          end
          PH_DATA: begin
            if (is_data_byte(b)) begin
              acc = absorb(acc, b);
              push(KIND_ECHO, 8'd0, 32'd0, 8'd0, b);
            end else begin
              push(KIND_RECORD, cur_attr, acc, groups, 8'd0);
              cur_attr = '0;
              acc      = '0;
              groups   = '0;
              phase    = PH_ATTR;
              attr_step(b);
            end
          end
          PH_ATTR: attr_step(b);
          default: begin
            if (b == end_flag) begin
              phase = PH_WAIT;
            end
          end
        endcase
      end

      if (run_len > 0) begin
        run_buf[run_len-1].last = 1'b1;
      end
      for (int i = 0; i < run_len; i++) begin
        pending_results.push_back(run_buf[i]);
      end
      return 1'b1;
    endfunction

    function string show(res_t r);
      return $sformatf("kind=%0d type=%0d ident=%h attr=%h value=%h count=%0d byte=%h last=%b",
                       r.kind, r.ptype, r.ident, r.attr, r.value, r.count, r.pbyte, r.last);
    endfunction

    // Compares one result transaction with the oldest expectation, field by field.
    function void check_result(res_t got);
      res_t  want;
      string bad;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: %s", show(got));
        end
        return;
      end
      want = pending_results.pop_front();
      bad  = "";
      if (got.kind !== want.kind) bad = {bad, " kind"};
      if (got.ptype !== want.ptype) bad = {bad, " type"};
      if (got.ident !== want.ident) bad = {bad, " ident"};
      if (got.attr !== want.attr) bad = {bad, " attr"};
      if (got.value !== want.value) bad = {bad, " value"};
      if (got.count !== want.count) bad = {bad, " count"};
      if (got.pbyte !== want.pbyte) bad = {bad, " byte"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch in%s", bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

/* tb/tb_framed_attribute_packet_parser_top.sv */
// Testbench top: drives bytes and settings into the packet parser and checks every result.
`timescale 1ns / 100ps
module tb_framed_attribute_packet_parser_top;
  import fapp_pkg::*;
  import fapp_tb_pkg::*;

  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned QuietCycles    = 12;
  localparam int unsigned PressureAt     = 300;
  localparam int unsigned PressureCycles = 80;
  localparam int unsigned NumSettings    = 7;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [7:0]         cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         byte_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         result_kind_o;
  logic [1:0]         packet_type_o;
  logic [31:0]        packet_ident_o;
  logic [7:0]         attribute_code_o;
  logic [31:0]        decoded_value_o;
  logic [7:0]         data_count_o;
  logic [7:0]         payload_byte_o;
  logic               last_of_run_o;

  parse_scoreboard sb;
  bit [7:0]        frame_q[$];
  int unsigned     used_items;
  int unsigned     cycle_count;
  bit              pressure_done;
  res_t            seen_res;

  // Register settings, in register index order: start X, Y, Z, end, attr first/last, payload.
  bit [7:0] setting_tab [NumSettings][7] = '{
    '{StartXRst, StartYRst, StartZRst, EndFlagRst, AttrFirstRst, AttrLastRst, PayloadFirstRst},
    '{8'd0,   8'd255, 8'd127, 8'd64,  8'd65,  8'd95,  8'd128},
    '{8'd9,   8'd9,   8'd9,   8'd199, 8'd0,   8'd198, 8'd200},
    '{8'd16,  8'd17,  8'd17,  8'd18,  8'd19,  8'd19,  8'd255},
    '{8'd170, 8'd187, 8'd204, 8'd32,  8'd255, 8'd16,  8'd64},
    '{8'd5,   8'd6,   8'd7,   8'd255, 8'd9,   8'd255, 8'd0},
    '{StartXRst, StartYRst, StartZRst, EndFlagRst, AttrFirstRst, AttrLastRst, PayloadFirstRst}
  };
  int unsigned phase_items [NumSettings] = '{450, 420, 100, 110, 40, 240, 90};

  // Opening bytes under the reset settings: wide ids and data, truncation, empty id,
  // format error with skipping, an ignored byte, and a record followed by an error.
  bit [7:0] directed_bytes [26] = '{
    8'd1, 8'hFF, 8'h00, 8'h80, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd31, 8'd4,
    8'd2, 8'd4,
    8'd3, 8'h20, 8'h01, 8'h55, 8'd4,
    8'h99,
    8'd2, 8'd5, 8'h40, 8'h02, 8'd4
  };

  framed_attribute_packet_parser_top u_dut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle rates: sender rarely and receiver often, then reversed, then no idling.
  function automatic int unsigned send_idle_pct();
    if (used_items < 520) return 9;
    else if (used_items < 1040) return 67;
    else return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (used_items < 520) return 67;
    else if (used_items < 1040) return 9;
    else return 0;
  endfunction

  // Byte pickers that follow the current settings.
  function automatic bit [7:0] pick_payload();
    if ($urandom_range(7) == 0) return 8'd0;
    return 8'($urandom_range(255, sb.payload_first));
  endfunction

  function automatic bit [7:0] pick_attr();
    bit [7:0] b;
    if (sb.attr_first <= sb.attr_last) begin
      repeat (32) begin
        b = 8'($urandom_range(sb.attr_last, sb.attr_first));
        if (!sb.is_data_byte(b)) return b;
      end
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic bit [7:0] pick_start();
    case ($urandom_range(2))
      0:       return sb.start_x;
      1:       return sb.start_y;
      default: return sb.start_z;
    endcase
  endfunction

  function automatic bit [7:0] pick_error();
    bit [7:0] b;
    repeat (64) begin
      b = 8'($urandom_range(255));
      if (!sb.is_data_byte(b) && !sb.is_attr(b) && b != sb.end_flag) return b;
    end
    return 8'($urandom_range(255));
  endfunction

  // Offers one byte and waits until it is accepted as a transaction.
  task automatic send_byte(input bit [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid_i = 1'b0;
      byte_in_i  = 8'($urandom_range(255));
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    byte_in_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    if (sb.take_byte(b)) used_items++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // Well-formed packet: start, id groups, attributes with data, end.
  task automatic build_good_frame();
    frame_q.delete();
    frame_q.push_back(pick_start());
    repeat ($urandom_range(6)) frame_q.push_back(pick_payload());
    repeat ($urandom_range(4)) begin
      frame_q.push_back(pick_attr());
      repeat ($urandom_range(7)) frame_q.push_back(pick_payload());
    end
    frame_q.push_back(sb.end_flag);
  endtask

  // Mostly well-formed packets, some with a byte replaced or inserted, some line noise.
  task automatic build_random_frame();
    int unsigned pick;
    int unsigned pos;
    pick = $urandom_range(9);
    if (pick == 9) begin
      frame_q.delete();
      repeat ($urandom_range(5, 1)) frame_q.push_back(8'($urandom_range(255)));
    end else begin
      build_good_frame();
      if (pick >= 7) begin
        pos = $urandom_range(frame_q.size() - 1);
        if ($urandom_range(1)) frame_q[pos] = 8'($urandom_range(255));
        else frame_q.insert(pos, 8'($urandom_range(255)));
      end
    end
  endtask

  // Packet right at the length limit: it ends fine, overflows on its end flag, or in its data.
  task automatic build_long_frame();
    int unsigned len;
    len = $urandom_range(257, 254);
    frame_q.delete();
    frame_q.push_back(pick_start());
    frame_q.push_back(pick_payload());
    frame_q.push_back(pick_attr());
    while (frame_q.size() < len - 1) frame_q.push_back(pick_payload());
    frame_q.push_back(sb.end_flag);
  endtask

  // Format error followed by a skip long enough to overflow the packet.
  task automatic build_skip_frame();
    bit [7:0] b;
    frame_q.delete();
    frame_q.push_back(pick_start());
    frame_q.push_back(pick_payload());
    frame_q.push_back(pick_error());
    while (frame_q.size() < 262) begin
      b = 8'($urandom_range(255));
      if (b != sb.end_flag) frame_q.push_back(b);
    end
  endtask

  // Writes all seven registers of one setting, one per cycle.
  task automatic load_setting(input int unsigned row);
    for (int i = 0; i < 7; i++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_index_i = cfg_idx_e'(i);
      cfg_wdata_i = setting_tab[row][i];
      sb.write_reg(cfg_idx_e'(i), setting_tab[row][i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Waits for every owed result, then lets bytes without results run through.
  task automatic wait_quiet();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // Stimulus: reset, then one phase per setting.
  initial begin
    int unsigned goal;
    sb            = new(MaxPacketBytesDef);
    goal          = 0;
    used_items    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_START_X;
    cfg_wdata_i   = 8'd0;
    in_valid_i    = 1'b0;
    byte_in_i     = 8'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned p = 0; p < NumSettings; p++) begin
      load_setting(p);
      if (p == 0) begin
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        build_long_frame();
        send_frame();
      end
      if (p == 1) begin
        build_skip_frame();
        send_frame();
      end
      goal += phase_items[p];
      while (used_items < goal) begin
        build_random_frame();
        send_frame();
      end
      // Close any open packet so the next setting starts from the wait phase.
      while (sb.phase != PH_WAIT) send_byte(sb.end_flag);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      wait_quiet();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up to its input.
  initial begin
    out_stall_i   = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && used_items >= PressureAt) begin
        pressure_done = 1'b1;
        out_stall_i   = 1'b1;
        repeat (PressureCycles) @(negedge clk_i);
      end
      out_stall_i = ($urandom_range(99) < recv_idle_pct());
    end
  end

  // Checks each result transaction as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_res.kind  = kind_e'(result_kind_o);
      seen_res.ptype = packet_type_o;
      seen_res.ident = packet_ident_o;
      seen_res.attr  = attribute_code_o;
      seen_res.value = decoded_value_o;
      seen_res.count = data_count_o;
      seen_res.pbyte = payload_byte_o;
      seen_res.last  = last_of_run_o;
      sb.check_result(seen_res);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/fapp_pkg.sv
rtl/fapp_front.sv
rtl/fapp_back.sv
rtl/framed_attribute_packet_parser_top.sv
tb/fapp_tb_pkg.sv
tb/tb_framed_attribute_packet_parser_top.sv
